// ----- hdl/pirl_pkg.sv -----
// ----------------------------------------------------------------------------
// pirl_pkg: shared types and constants of the positional insert/remove list
// Command and status codes and the fixed widths of the request and response
// fields.
// ----------------------------------------------------------------------------
package pirl_pkg;

	localparam int CMD_W    = 2;
	localparam int POS_W    = 7;
	localparam int VALUE_W  = 32;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

// ----- hdl/pirl_if.sv -----
// ----------------------------------------------------------------------------
// pirl_if: request and response channels of the positional insert/remove list
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pirl_req_if;
	logic                          valid;
	logic                          ready;
	logic [pirl_pkg::CMD_W-1:0]    cmd;
	logic [pirl_pkg::POS_W-1:0]    position;
	logic [pirl_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output cmd, output position, output value, input ready);
	modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface pirl_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [pirl_pkg::DATA_W-1:0]     data;
	logic [pirl_pkg::STATUS_W-1:0]   status;
	logic [pirl_pkg::COUNT_W-1:0]    count;

	modport source (output valid, output data, output status, output count, input ready);
	modport sink   (input valid, input data, input status, input count, output ready);
endinterface

// ----- hdl/positional_insert_remove_list.sv -----
// ----------------------------------------------------------------------------
// positional_insert_remove_list: ordered list with insert/remove/read at index
// Entries live in a single-port-write, single-port-read memory; a small
// sequencer moves them one per cycle to open or close a gap.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command (insert, remove, read) with a position and, for
//   insert, a value. rsp returns one result per request: data, status, count.
//   Per command, with position p:
//     insert : entries at and above p move up one per cycle; p is then written
//     remove : entries above p move down one per cycle
//     read   : the entry at p is read; nothing moves
//     error  : no entry moves (bad position, list full, unused command)
//   The single memory port pair sets the pace: one entry moved per cycle.
//   req.ready is high only when the sequencer is idle and the response
//   register is empty, so the next request is taken the cycle after the
//   response transfer.
//   A stalled receiver holds the response and blocks new requests.
//   Reset empties the list (count zero); the memory itself is not cleared,
//   only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_insert_remove_list #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	pirl_req_if.sink       req,
	pirl_rsp_if.source     rsp
);

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int PW  = (CW > pirl_pkg::POS_W) ? CW : pirl_pkg::POS_W;
	localparam int CXW = (CW > pirl_pkg::COUNT_W) ? CW : pirl_pkg::COUNT_W;
	localparam int DXW = (DATA_WIDTH > pirl_pkg::VALUE_W) ? DATA_WIDTH : pirl_pkg::VALUE_W;

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_UP   = 5'b00010,
		S_PUT  = 5'b00100,
		S_DOWN = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         fill_q;
	logic                  pend_q;
	logic                  rvalid_q;

	logic [CW-1:0]         ptr_q;
	logic [CW-1:0]         lim_q;
	logic [AW-1:0]         pos_q;
	logic [AW-1:0]         wr_addr_q;
	logic                  cap_q;
	logic                  rm_q;
	word_t                 val_q;
	word_t                 data_q;
	word_t                 rdata_q;
	logic [pirl_pkg::DATA_W-1:0]   rsp_data_q;
	logic [pirl_pkg::STATUS_W-1:0] rsp_status_q;
	logic [pirl_pkg::COUNT_W-1:0]  rsp_count_q;

	word_t                 mem [DEPTH];

	logic                  accept;
	logic [PW-1:0]         pos_ext;
	logic [PW-1:0]         fill_ext;
	logic [DXW-1:0]        val_ext;
	logic [DXW-1:0]        data_ext;
	logic [CW-1:0]         ptr_dec;
	logic [CW-1:0]         pos_w;
	logic                  up_issue;
	logic                  down_issue;
	logic                  req_ok;
	pirl_pkg::status_t     req_status;
	state_t                req_next;
	logic [CW-1:0]         fill_new;
	logic [CXW-1:0]        fill_new_ext;
	logic [CXW-1:0]        fill_cur_ext;

	logic                  mem_re;
	logic [AW-1:0]         mem_ra;
	logic                  mem_we;
	logic [AW-1:0]         mem_wa;
	word_t                 mem_wd;

	assign req.ready  = (state_q == S_IDLE) && !rvalid_q;
	assign accept     = req.valid && req.ready;
	assign pos_ext    = PW'(req.position);
	assign fill_ext   = PW'(fill_q);
	assign val_ext    = DXW'(req.value);
	assign data_ext   = DXW'(data_q);
	assign ptr_dec    = ptr_q - CW'(1);
	assign pos_w      = CW'(pos_q);
	assign up_issue   = ptr_q > pos_w;
	assign down_issue = ptr_q < lim_q;

	// decode and range check of an incoming request
	always_comb begin
		req_ok     = 1'b0;
		req_status = pirl_pkg::ST_RANGE;
		req_next   = S_IDLE;
		case (req.cmd)
			pirl_pkg::CMD_INSERT: begin
				if (pos_ext > fill_ext) begin
					req_status = pirl_pkg::ST_RANGE;
				end else if (fill_q == CW'(DEPTH)) begin
					req_status = pirl_pkg::ST_FULL;
				end else begin
					req_ok     = 1'b1;
					req_status = pirl_pkg::ST_OK;
					req_next   = S_UP;
				end
			end
			pirl_pkg::CMD_REMOVE, pirl_pkg::CMD_READ: begin
				if (pos_ext < fill_ext) begin
					req_ok     = 1'b1;
					req_status = pirl_pkg::ST_OK;
					req_next   = S_DOWN;
				end
			end
			default: begin
				req_status = pirl_pkg::ST_RANGE;
			end
		endcase
	end

	// memory port control
	always_comb begin
		mem_re = 1'b0;
		mem_ra = ptr_q[AW-1:0];
		mem_we = 1'b0;
		mem_wa = wr_addr_q;
		mem_wd = rdata_q;
		case (state_q)
			S_UP: begin
				mem_re = up_issue;
				mem_ra = ptr_dec[AW-1:0];
				mem_we = pend_q;
			end
			S_DOWN: begin
				mem_re = down_issue;
				mem_we = pend_q && !cap_q;
			end
			S_PUT: begin
				mem_we = 1'b1;
				mem_wa = pos_q;
				mem_wd = val_q;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	assign fill_new     = (state_q == S_PUT) ? (fill_q + CW'(1)) :
	                      (rm_q ? (fill_q - CW'(1)) : fill_q);
	assign fill_new_ext = CXW'(fill_new);
	assign fill_cur_ext = CXW'(fill_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			pend_q   <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= req_next;
						pend_q  <= 1'b0;
						if (!req_ok) begin
							rvalid_q <= 1'b1;
						end
					end
				end
				S_UP: begin
					pend_q <= up_issue;
					if (!up_issue) begin
						state_q <= S_PUT;
					end
				end
				S_DOWN: begin
					pend_q <= down_issue;
					if (!down_issue) begin
						state_q <= S_FIN;
					end
				end
				S_PUT, S_FIN: begin
					fill_q   <= fill_new;
					rvalid_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// sequencer datapath and response register
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					pos_q        <= pos_ext[AW-1:0];
					val_q        <= val_ext[DATA_WIDTH-1:0];
					rm_q         <= (req.cmd == pirl_pkg::CMD_REMOVE);
					cap_q        <= 1'b0;
					if (req.cmd == pirl_pkg::CMD_INSERT) begin
						ptr_q <= fill_q;
					end else begin
						ptr_q <= pos_ext[CW-1:0];
					end
					if (req.cmd == pirl_pkg::CMD_REMOVE) begin
						lim_q <= fill_q;
					end else begin
						lim_q <= pos_ext[CW-1:0] + CW'(1);
					end
					if (!req_ok) begin
						rsp_data_q   <= '0;
						rsp_status_q <= req_status;
						rsp_count_q  <= fill_cur_ext[pirl_pkg::COUNT_W-1:0];
					end
				end
			end
			S_UP: begin
				if (up_issue) begin
					wr_addr_q <= ptr_q[AW-1:0];
					ptr_q     <= ptr_dec;
				end
			end
			S_DOWN: begin
				// first word read is the result, the rest shift down by one
				if (pend_q && cap_q) begin
					data_q <= rdata_q;
				end
				if (down_issue) begin
					cap_q     <= (ptr_q == pos_w);
					wr_addr_q <= ptr_dec[AW-1:0];
					ptr_q     <= ptr_q + CW'(1);
				end
			end
			S_PUT: begin
				rsp_data_q   <= '0;
				rsp_status_q <= pirl_pkg::ST_OK;
				rsp_count_q  <= fill_new_ext[pirl_pkg::COUNT_W-1:0];
			end
			S_FIN: begin
				rsp_data_q   <= data_ext[pirl_pkg::DATA_W-1:0];
				rsp_status_q <= pirl_pkg::ST_OK;
				rsp_count_q  <= fill_new_ext[pirl_pkg::COUNT_W-1:0];
				rm_q         <= 1'b0;
			end
			default: begin
				cap_q <= 1'b0;
			end
		endcase
	end

	assign rsp.valid  = rvalid_q;
	assign rsp.data   = rsp_data_q;
	assign rsp.status = rsp_status_q;
	assign rsp.count  = rsp_count_q;

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("fill count above capacity");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> ($past(state_q) == S_PUT || $past(state_q) == S_FIN))
		else $error("fill count changed outside the finish step");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rvalid_q) |-> ($past(state_q) == S_IDLE || $past(state_q) == S_PUT
			|| $past(state_q) == S_FIN))
		else $error("response raised while entries still moving");

	a_up_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP && pend_q) |-> (wr_addr_q > pos_q))
		else $error("insert shift writes at or below the insert position");

	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !req.ready)
		else $error("request taken while the sequencer is busy");
`endif

endmodule
